// File: hdl/slq_pkg.sv
`timescale 1ns / 1ps

package slq_pkg;

  // Default sizes
  localparam int POOL_ENTRIES_DEF = 256;
  localparam int NUM_QUEUES_DEF   = 8;
  localparam int WORD_BITS_DEF    = 16;

  // Fixed field widths
  localparam int OP_BITS     = 3;
  localparam int QID_BITS    = 3;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 8;
  localparam int LIMIT_BITS  = 8;

  // Reset value of the normal-queue limit: nine tenths of the default pool
  localparam logic [LIMIT_BITS-1:0] NORMAL_LIMIT_RST =
    LIMIT_BITS'((9 * POOL_ENTRIES_DEF) / 10);

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_PUT    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_GET    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SETPRI = 3'd4;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic sweep;
    logic accept;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/slq_cmd_if.sv
`timescale 1ns / 1ps

interface slq_cmd_if #(
  parameter int WORD_BITS = slq_pkg::WORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [slq_pkg::OP_BITS-1:0]  operation;
  logic [slq_pkg::QID_BITS-1:0] queue_id;
  logic [WORD_BITS-1:0]         data_in;
  logic                         priority_in;

  modport source (output valid, output operation, output queue_id, output data_in,
                  output priority_in, input ready);
  modport sink   (input valid, input operation, input queue_id, input data_in,
                  input priority_in, output ready);
endinterface

// File: hdl/slq_rsp_if.sv
`timescale 1ns / 1ps

interface slq_rsp_if #(
  parameter int WORD_BITS = slq_pkg::WORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [slq_pkg::STATUS_BITS-1:0] status;
  logic [WORD_BITS-1:0]            data_out;
  logic [slq_pkg::COUNT_BITS-1:0]  count;

  modport source (output valid, output status, output data_out, output count,
                  input ready);
  modport sink   (input valid, input status, input data_out, input count,
                  output ready);
endinterface

// File: hdl/slq_ctrl.sv
`timescale 1ns / 1ps

module slq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  slq_pkg::dp_stat_t stat,
  output slq_pkg::ctl_cmd_t ctl
);

  slq_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slq_pkg::S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      slq_pkg::S_SWEEP: begin
        if (stat.sweep_last) state_next = slq_pkg::S_IDLE;
      end
      slq_pkg::S_IDLE: begin
        if (cmd_valid) state_next = slq_pkg::S_EXEC;
      end
      slq_pkg::S_EXEC: begin
        // hold while the result register is still occupied
        if (stat.out_free) state_next = slq_pkg::S_IDLE;
      end
      default: begin
        state_next = slq_pkg::S_SWEEP;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctl       = '0;
    cmd_ready = 1'b0;
    case (state)
      slq_pkg::S_SWEEP: begin
        ctl.sweep = 1'b1;
      end
      slq_pkg::S_IDLE: begin
        cmd_ready  = 1'b1;
        ctl.accept = cmd_valid;
      end
      slq_pkg::S_EXEC: begin
        ctl.commit = stat.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// File: hdl/slq_datapath.sv
`timescale 1ns / 1ps

module slq_datapath #(
  parameter int POOL_ENTRIES = slq_pkg::POOL_ENTRIES_DEF,
  parameter int NUM_QUEUES   = slq_pkg::NUM_QUEUES_DEF,
  parameter int WORD_BITS    = slq_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // item payload
  input  logic [slq_pkg::OP_BITS-1:0]       operation,
  input  logic [slq_pkg::QID_BITS-1:0]      queue_id,
  input  logic [WORD_BITS-1:0]              data_in,
  input  logic                              priority_in,
  // result
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [slq_pkg::STATUS_BITS-1:0]   rsp_status,
  output logic [WORD_BITS-1:0]              rsp_data_out,
  output logic [slq_pkg::COUNT_BITS-1:0]    rsp_count,
  // limit register
  input  logic                              cfg_we,
  input  logic [slq_pkg::LIMIT_BITS-1:0]    cfg_wdata,
  // control
  input  slq_pkg::ctl_cmd_t                 ctl,
  output slq_pkg::dp_stat_t                 stat
);

  localparam int PTR_W  = $clog2(POOL_ENTRIES);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // Pool memories
  logic [PTR_W-1:0]     link_mem [POOL_ENTRIES];
  logic [WORD_BITS-1:0] word_mem [POOL_ENTRIES];
  logic [PTR_W-1:0]     link_rd;
  logic [WORD_BITS-1:0] word_rd;

  // Pool and queue state
  logic [PTR_W-1:0] free_head, free_head_next;
  logic [PTR_W-1:0] used, used_next;
  logic [PTR_W-1:0] q_head  [NUM_QUEUES];
  logic [PTR_W-1:0] q_tail  [NUM_QUEUES];
  logic [PTR_W-1:0] q_count [NUM_QUEUES];
  logic             q_pri   [NUM_QUEUES];
  logic [slq_pkg::LIMIT_BITS-1:0] normal_limit;
  logic [PTR_W-1:0] sweep_addr;

  // Latched item
  logic [slq_pkg::OP_BITS-1:0] op_r;
  logic                        q_ok_r;
  logic [QIDX_W-1:0]           q_idx_r;
  logic [WORD_BITS-1:0]        data_r;
  logic                        pri_r;

  // Item decode at the input
  logic              q_ok_in;
  logic [QIDX_W-1:0] q_idx_in;
  logic [PTR_W-1:0]  rd_addr;

  // Commit values
  logic [PTR_W-1:0] cur_head, cur_tail, cur_count;
  logic             cur_pri;
  logic [PTR_W-1:0] head_next, tail_next, count_next;
  logic             pri_next;
  logic [slq_pkg::STATUS_BITS-1:0] st;
  logic [WORD_BITS-1:0]            dout;
  logic [PTR_W-1:0]                cnt_rep;
  logic             link_we;
  logic [PTR_W-1:0] link_wa, link_wd;
  logic             word_we;

  assign q_ok_in  = 32'(queue_id) < NUM_QUEUES;
  assign q_idx_in = q_ok_in ? QIDX_W'(32'(queue_id)) : '0;
  // put reads the free head's link, get and peek read the queue head
  assign rd_addr  = (operation == slq_pkg::OP_PUT) ? free_head : q_head[q_idx_in];

  assign stat.sweep_last = (sweep_addr == PTR_W'(POOL_ENTRIES - 1));
  assign stat.out_free   = !rsp_valid || rsp_ready;

  assign cur_head  = q_head[q_idx_r];
  assign cur_tail  = q_tail[q_idx_r];
  assign cur_count = q_count[q_idx_r];
  assign cur_pri   = q_pri[q_idx_r];

  // Operation logic
  always_comb begin
    st             = slq_pkg::ST_OK;
    dout           = '0;
    cnt_rep        = q_ok_r ? cur_count : '0;
    free_head_next = free_head;
    used_next      = used;
    head_next      = cur_head;
    tail_next      = cur_tail;
    count_next     = cur_count;
    pri_next       = cur_pri;
    link_we        = 1'b0;
    link_wa        = cur_tail;
    link_wd        = free_head;
    word_we        = 1'b0;
    if (ctl.sweep) begin
      // build the initial free chain, last entry ends it
      link_we = 1'b1;
      link_wa = sweep_addr;
      link_wd = stat.sweep_last ? '0 : sweep_addr + PTR_W'(1);
    end else if (ctl.commit && q_ok_r) begin
      case (op_r)
        slq_pkg::OP_PUT: begin
          if (free_head == '0 ||
              (!cur_pri && 32'(used) >= 32'(normal_limit))) begin
            st = slq_pkg::ST_FULL;
          end else begin
            free_head_next = link_rd;
            used_next      = used + PTR_W'(1);
            word_we        = 1'b1;
            if (cur_count == '0) begin
              head_next = free_head;
            end else begin
              link_we = 1'b1;
              link_wa = cur_tail;
              link_wd = free_head;
            end
            tail_next  = free_head;
            count_next = cur_count + PTR_W'(1);
            cnt_rep    = count_next;
          end
        end
        slq_pkg::OP_GET: begin
          if (cur_head == '0) begin
            st = slq_pkg::ST_EMPTY;
          end else begin
            count_next = cur_count - PTR_W'(1);
            if (count_next == '0) begin
              head_next = '0;
              tail_next = '0;
            end else begin
              head_next = link_rd;
            end
            // freed entry goes to the front of the free list
            link_we        = 1'b1;
            link_wa        = cur_head;
            link_wd        = free_head;
            dout           = word_rd;
            free_head_next = cur_head;
            used_next      = used - PTR_W'(1);
            cnt_rep        = count_next;
          end
        end
        slq_pkg::OP_PEEK: begin
          if (cur_head == '0) begin
            st = slq_pkg::ST_EMPTY;
          end else begin
            dout = word_rd;
          end
        end
        slq_pkg::OP_CLEAR: begin
          if (cur_count != '0) begin
            // splice the whole chain in front of the free list
            used_next      = used - cur_count;
            link_we        = 1'b1;
            link_wa        = cur_tail;
            link_wd        = free_head;
            free_head_next = cur_head;
            count_next     = '0;
            head_next      = '0;
            tail_next      = '0;
            pri_next       = 1'b0;
          end
          cnt_rep = '0;
        end
        slq_pkg::OP_SETPRI: begin
          pri_next = pri_r;
        end
        default: begin
          st = slq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Pool memories
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (ctl.accept) link_rd <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (word_we) word_mem[free_head] <= data_r;
    if (ctl.accept) word_rd <= word_mem[rd_addr];
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_r    <= operation;
      q_ok_r  <= q_ok_in;
      q_idx_r <= q_idx_in;
      data_r  <= data_in;
      pri_r   <= priority_in;
    end
  end

  // Pool and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= PTR_W'(1);
      used       <= '0;
      sweep_addr <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        q_head[i]  <= '0;
        q_tail[i]  <= '0;
        q_count[i] <= '0;
        q_pri[i]   <= 1'b0;
      end
    end else begin
      if (ctl.sweep) sweep_addr <= sweep_addr + PTR_W'(1);
      if (ctl.commit && q_ok_r) begin
        free_head        <= free_head_next;
        used             <= used_next;
        q_head[q_idx_r]  <= head_next;
        q_tail[q_idx_r]  <= tail_next;
        q_count[q_idx_r] <= count_next;
        q_pri[q_idx_r]   <= pri_next;
      end
    end
  end

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_limit <= slq_pkg::NORMAL_LIMIT_RST;
    end else if (cfg_we) begin
      normal_limit <= cfg_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp_status   <= st;
      rsp_data_out <= dout;
      rsp_count    <= slq_pkg::COUNT_BITS'(32'(cnt_rep));
    end
  end

endmodule

// File: hdl/shared_pool_linked_queues_top.sv
`timescale 1ns / 1ps
// Pipeline: an accepted word is latched with its link and word memory reads;
//   the result register loads it on the commit, once that register is free.
// Acceptance: no new word is taken until the last one has committed, since the
//   link and word memories are read in a registered step ahead of the commit.
// Reset: synchronous; afterwards a clearing pass over all POOL_ENTRIES entries
//   builds the free chain in link memory, during which no word is accepted.

module shared_pool_linked_queues_top #(
  parameter int POOL_ENTRIES = slq_pkg::POOL_ENTRIES_DEF,
  parameter int NUM_QUEUES   = slq_pkg::NUM_QUEUES_DEF,
  parameter int WORD_BITS    = slq_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  slq_cmd_if.sink                        cmd,
  slq_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [slq_pkg::LIMIT_BITS-1:0] cfg_wdata
);

  slq_pkg::ctl_cmd_t ctl;
  slq_pkg::dp_stat_t stat;
  logic              cmd_ready;

  assign cmd.ready = cmd_ready;

  slq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  slq_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .NUM_QUEUES   (NUM_QUEUES),
    .WORD_BITS    (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .operation    (cmd.operation),
    .queue_id     (cmd.queue_id),
    .data_in      (cmd.data_in),
    .priority_in  (cmd.priority_in),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_data_out (rsp.data_out),
    .rsp_count    (rsp.count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .ctl          (ctl),
    .stat         (stat)
  );

endmodule

// File: hdl/slq_checker.sv
`timescale 1ns / 1ps

module slq_checker #(
  parameter int WORD_BITS = slq_pkg::WORD_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [slq_pkg::STATUS_BITS-1:0] rsp_status,
  input logic [WORD_BITS-1:0]            rsp_data_out,
  input logic [slq_pkg::COUNT_BITS-1:0]  rsp_count
);

  // only the three defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == slq_pkg::ST_OK || rsp_status == slq_pkg::ST_EMPTY ||
                   rsp_status == slq_pkg::ST_FULL))
    else $error("undefined status code");

  // an empty queue reports no data and a zero count
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == slq_pkg::ST_EMPTY) |-> (rsp_data_out == '0 && rsp_count == '0))
    else $error("empty result carries data or count");

  // a refused put returns no data
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == slq_pkg::ST_FULL) |-> (rsp_data_out == '0))
    else $error("refused put carries data");

  // one word at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("word accepted back to back");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
                                   $stable(rsp_data_out) && $stable(rsp_count)))
    else $error("stalled result changed");

endmodule

bind shared_pool_linked_queues_top slq_checker #(
  .WORD_BITS (WORD_BITS)
) u_slq_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_data_out (rsp.data_out),
  .rsp_count    (rsp.count)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int ENTRY_BITS = $clog2(slq_pkg::POOL_ENTRIES_DEF);
  localparam int QUEUES     = slq_pkg::NUM_QUEUES_DEF;
  localparam int WBITS      = slq_pkg::WORD_BITS_DEF;
  localparam int POOL       = slq_pkg::POOL_ENTRIES_DEF;
  localparam int OPB        = slq_pkg::OP_BITS;
  localparam int QIDB       = slq_pkg::QID_BITS;
  localparam int LIMB       = slq_pkg::LIMIT_BITS;

  // Operation codes the block ignores
  localparam logic [OPB-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPB-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OPB-1:0]  kind;
    logic [QIDB-1:0] qid;
    logic [WBITS-1:0] word;
    logic            pri;
  } queue_cmd_t;

  typedef struct packed {
    logic [slq_pkg::STATUS_BITS-1:0] status;
    logic [WBITS-1:0]                word;
    logic [slq_pkg::COUNT_BITS-1:0]  count;
  } queue_rsp_t;

  logic clk;
  logic rst;
  logic cfg_we = 1'b0;
  logic [LIMB-1:0] cfg_wdata = '0;

  slq_cmd_if cmd_bus ();
  slq_rsp_if rsp_bus ();

  shared_pool_linked_queues_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the pool, the queues and the limit register
  logic [ENTRY_BITS-1:0] nxt_link [POOL];
  logic [WBITS-1:0]      word_mem [POOL];
  logic [ENTRY_BITS-1:0] free_ptr;
  logic [ENTRY_BITS-1:0] used_cnt;
  logic [ENTRY_BITS-1:0] q_head [QUEUES];
  logic [ENTRY_BITS-1:0] q_tail [QUEUES];
  logic [slq_pkg::COUNT_BITS-1:0] q_len [QUEUES];
  logic                  q_pri  [QUEUES];
  logic [LIMB-1:0]       limit_shadow;

  queue_cmd_t cmd_backlog [$];
  queue_rsp_t pending_results [$];
  int  words_loaded = 0;
  int  words_taken  = 0;
  int  mismatches   = 0;
  int  send_idle_pct = 21;
  int  recv_idle_pct = 61;
  logic cmd_taken = 1'b0;

  // Pool after reset: free chain 1 -> 2 -> ... -> last -> null
  function automatic void reset_pool_model();
    for (int i = 0; i < POOL; i++) begin
      nxt_link[i] = (i >= 1 && i < POOL - 1) ? ENTRY_BITS'(i + 1) : '0;
      word_mem[i] = '0;
    end
    for (int i = 0; i < QUEUES; i++) begin
      q_head[i] = '0;
      q_tail[i] = '0;
      q_len[i]  = '0;
      q_pri[i]  = 1'b0;
    end
    free_ptr     = ENTRY_BITS'(1);
    used_cnt     = '0;
    limit_shadow = slq_pkg::NORMAL_LIMIT_RST;
  endfunction

  // Apply one accepted word to the shadow state and return its result
  function automatic queue_rsp_t apply_queue_op(queue_cmd_t c);
    queue_rsp_t r;
    logic [ENTRY_BITS-1:0] e;
    r.status = slq_pkg::ST_OK;
    r.word   = '0;
    r.count  = q_len[c.qid];
    case (c.kind)
      slq_pkg::OP_PUT: begin
        e = free_ptr;
        if (e == '0 || (!q_pri[c.qid] && used_cnt >= limit_shadow)) begin
          r.status = slq_pkg::ST_FULL;
        end else begin
          free_ptr    = nxt_link[e];
          used_cnt    = used_cnt + 1'b1;
          nxt_link[e] = '0;
          word_mem[e] = c.word;
          if (q_len[c.qid] == '0) begin
            q_head[c.qid] = e;
          end else begin
            nxt_link[q_tail[c.qid]] = e;
          end
          q_tail[c.qid] = e;
          q_len[c.qid]  = q_len[c.qid] + 1'b1;
          r.count       = q_len[c.qid];
        end
      end
      slq_pkg::OP_GET: begin
        e = q_head[c.qid];
        if (e == '0) begin
          r.status = slq_pkg::ST_EMPTY;
        end else begin
          q_len[c.qid] = q_len[c.qid] - 1'b1;
          if (q_len[c.qid] == '0) begin
            q_head[c.qid] = '0;
            q_tail[c.qid] = '0;
          end else begin
            q_head[c.qid] = nxt_link[e];
          end
          nxt_link[e] = free_ptr;
          r.word      = word_mem[e];
          free_ptr    = e;
          used_cnt    = used_cnt - 1'b1;
          r.count     = q_len[c.qid];
        end
      end
      slq_pkg::OP_PEEK: begin
        e = q_head[c.qid];
        if (e == '0) r.status = slq_pkg::ST_EMPTY;
        else r.word = word_mem[e];
      end
      slq_pkg::OP_CLEAR: begin
        // whole chain goes back onto the free list in one splice
        if (q_len[c.qid] != '0) begin
          used_cnt                = used_cnt - ENTRY_BITS'(q_len[c.qid]);
          nxt_link[q_tail[c.qid]] = free_ptr;
          free_ptr                = q_head[c.qid];
          q_len[c.qid]            = '0;
          q_head[c.qid]           = '0;
          q_tail[c.qid]           = '0;
          q_pri[c.qid]            = 1'b0;
        end
        r.count = '0;
      end
      slq_pkg::OP_SETPRI: begin
        q_pri[c.qid] = c.pri;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 200) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic void push_cmd(logic [OPB-1:0] kind, logic [QIDB-1:0] qid,
                                   logic [WBITS-1:0] word, logic pri);
    queue_cmd_t c;
    c.kind = kind;
    c.qid  = qid;
    c.word = word;
    c.pri  = pri;
    cmd_backlog.push_back(c);
    words_loaded++;
  endfunction

  // Random word; put_pct sets how often it is a put
  function automatic void push_mixed(int put_pct);
    int roll;
    logic [OPB-1:0] kind;
    roll = $urandom_range(99);
    if (roll < put_pct) begin
      kind = slq_pkg::OP_PUT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 40)      kind = slq_pkg::OP_GET;
      else if (roll < 60) kind = slq_pkg::OP_PEEK;
      else if (roll < 72) kind = slq_pkg::OP_CLEAR;
      else if (roll < 92) kind = slq_pkg::OP_SETPRI;
      else                kind = OPB'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    push_cmd(kind, QIDB'($urandom_range(QUEUES - 1)), WBITS'($urandom),
             1'($urandom_range(1)));
  endfunction

  // Mostly puts onto the priority queues 0..3, to run the pool dry
  function automatic void push_fill();
    if ($urandom_range(99) < 95)
      push_cmd(slq_pkg::OP_PUT, QIDB'($urandom_range(3)), WBITS'($urandom),
               1'($urandom_range(1)));
    else
      push_mixed(0);
  endfunction

  function automatic void push_drain();
    int roll;
    logic [QIDB-1:0] qid;
    roll = $urandom_range(99);
    qid  = QIDB'($urandom_range(QUEUES - 1));
    if (roll < 45)
      push_cmd(slq_pkg::OP_GET, qid, WBITS'($urandom), 1'($urandom_range(1)));
    else if (roll < 60)
      push_cmd(slq_pkg::OP_PEEK, qid, WBITS'($urandom), 1'($urandom_range(1)));
    else if (roll < 75)
      push_cmd(slq_pkg::OP_CLEAR, qid, WBITS'($urandom), 1'($urandom_range(1)));
    else
      push_mixed(30);
  endfunction

  // Block idle: nothing queued, nothing in flight, nothing outstanding
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || words_taken != words_loaded ||
           pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMB-1:0] v);
    @(negedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= v;
    limit_shadow = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Command driver: hold a word until taken, otherwise maybe idle
  always @(negedge clk) begin : drive_cmd
    queue_cmd_t nxt;
    if (!rst) begin
      if (!(cmd_bus.valid && !cmd_taken)) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_backlog.pop_front();
          cmd_bus.valid       <= 1'b1;
          cmd_bus.operation   <= nxt.kind;
          cmd_bus.queue_id    <= nxt.qid;
          cmd_bus.data_in     <= nxt.word;
          cmd_bus.priority_in <= nxt.pri;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check results, predict on each accepted command
  always @(posedge clk) begin : watch_bus
    queue_cmd_t acc;
    queue_rsp_t got;
    queue_rsp_t want;
    cmd_taken = 1'b0;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.status = rsp_bus.status;
        got.word   = rsp_bus.data_out;
        got.count  = rsp_bus.count;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d data=%h count=%0d",
                                    got.status, got.word, got.count));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.word !== want.word ||
              got.count !== want.count)
            report_mismatch($sformatf("status %0d/%0d data %h/%h count %0d/%0d (got/exp)",
                                      got.status, want.status, got.word, want.word,
                                      got.count, want.count));
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        acc.kind = cmd_bus.operation;
        acc.qid  = cmd_bus.queue_id;
        acc.word = cmd_bus.data_in;
        acc.pri  = cmd_bus.priority_in;
        pending_results.push_back(apply_queue_op(acc));
        words_taken++;
        cmd_taken = 1'b1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst                 = 1'b1;
    cmd_bus.valid       = 1'b0;
    cmd_bus.operation   = slq_pkg::OP_PUT;
    cmd_bus.queue_id    = '0;
    cmd_bus.data_in     = '0;
    cmd_bus.priority_in = 1'b0;
    rsp_bus.ready       = 1'b0;
    reset_pool_model();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty queue cases, priority, data extremes, spare codes
    push_cmd(slq_pkg::OP_PEEK,   3'd0, 16'h0000, 1'b0);
    push_cmd(slq_pkg::OP_GET,    3'd0, 16'hFFFF, 1'b1);
    push_cmd(slq_pkg::OP_CLEAR,  3'd0, 16'h0000, 1'b0);
    push_cmd(slq_pkg::OP_SETPRI, 3'd5, 16'h0000, 1'b1);
    push_cmd(slq_pkg::OP_CLEAR,  3'd5, 16'h0000, 1'b0);   // empty: flag must survive
    push_cmd(slq_pkg::OP_PUT,    3'd5, 16'hFFFF, 1'b0);
    push_cmd(slq_pkg::OP_PUT,    3'd5, 16'h0000, 1'b1);
    push_cmd(slq_pkg::OP_PEEK,   3'd5, 16'h0000, 1'b0);
    push_cmd(slq_pkg::OP_GET,    3'd5, 16'h0000, 1'b0);
    push_cmd(slq_pkg::OP_GET,    3'd5, 16'h0000, 1'b0);
    push_cmd(slq_pkg::OP_PUT,    3'd5, 16'hA5A5, 1'b0);
    push_cmd(slq_pkg::OP_CLEAR,  3'd5, 16'h0000, 1'b0);   // non-empty: flag dropped
    push_cmd(slq_pkg::OP_SETPRI, 3'd5, 16'h0000, 1'b0);
    push_cmd(OP_SPARE_LO,        3'd3, 16'h5A5A, 1'b1);
    push_cmd(OP_SPARE_LO + 3'd1, 3'd3, 16'hFFFF, 1'b0);
    push_cmd(OP_SPARE_HI,        3'd7, 16'h0001, 1'b1);
    push_cmd(slq_pkg::OP_PUT,    3'd7, 16'h8001, 1'b0);
    push_cmd(slq_pkg::OP_PUT,    3'd7, 16'h7FFE, 1'b1);
    push_cmd(slq_pkg::OP_PUT,    3'd0, 16'h1234, 1'b0);
    push_cmd(slq_pkg::OP_GET,    3'd7, 16'h0000, 1'b0);
    push_cmd(slq_pkg::OP_PEEK,   3'd7, 16'h0000, 1'b0);
    push_cmd(slq_pkg::OP_CLEAR,  3'd7, 16'h0000, 1'b0);
    push_cmd(slq_pkg::OP_PUT,    3'd2, 16'hC3C3, 1'b1);

    // Low limit: normal queues get refused early
    wait_drained();
    write_limit(8'd20);
    repeat (120) push_mixed(55);

    // Limit at max, priority on queues 0..3, then run the pool dry
    wait_drained();
    send_idle_pct = 61;
    recv_idle_pct = 21;
    write_limit(8'd255);
    for (int i = 0; i < 4; i++)
      push_cmd(slq_pkg::OP_SETPRI, QIDB'(i), WBITS'($urandom), 1'b1);
    repeat (270) push_fill();
    repeat (50) push_drain();

    // Limit zero: only priority queues may grow
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(8'd0);
    repeat (80) push_mixed(50);

    // Random limit
    wait_drained();
    write_limit(LIMB'($urandom_range(1, 254)));
    repeat (120) push_mixed(45);

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/slq_pkg.sv
hdl/slq_cmd_if.sv
hdl/slq_rsp_if.sv
hdl/slq_ctrl.sv
hdl/slq_datapath.sv
hdl/shared_pool_linked_queues_top.sv
hdl/slq_checker.sv
dv/tb_top.sv
